// ===== rtl/core/ssr_pkg.sv =====
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types, register codes and sizing constants for the stream
// substring replace core.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int MAX_PATTERN_DEF     = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;

  // a job carries up to this many output bytes
  localparam int JOB_MAX_BYTES = 8;
  localparam int JOB_CNT_W     = $clog2(JOB_MAX_BYTES + 1);
  localparam int JOB_IDX_W     = $clog2(JOB_MAX_BYTES);

  localparam int QUEUE_DEPTH = 4;
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // one queued emission: first count bytes of data, byte 0 first
  typedef struct packed {
    logic [8*JOB_MAX_BYTES-1:0] data;
    logic [JOB_CNT_W-1:0]       count;
    logic                       last;
  } job_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QLVL_W-1:0] level;
  } q_status_t;

endpackage

// ===== rtl/core/ssr_front.sv =====
// ----------------------------------------------------------------------------
// ssr_front
// Holds configuration and the pending match window, classifies each input
// byte and turns it into at most one output job per transfer.
// ----------------------------------------------------------------------------
module ssr_front
  import ssr_pkg::*;
#(
  parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  in_item_t              in_item,
  input  logic                  accept,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  job_push,
  output job_t                  job
);

  localparam int FW = $clog2(MAX_PATTERN + 1);

  logic [63:0]   pat_bytes_r, pat_bytes_nxt;
  logic [3:0]    pat_len_r, pat_len_nxt;
  logic [63:0]   rep_bytes_r, rep_bytes_nxt;
  logic [3:0]    rep_len_r, rep_len_nxt;
  logic [7:0]    window_r [MAX_PATTERN];
  logic [7:0]    window_nxt [MAX_PATTERN];
  logic [FW-1:0] fill_r, fill_nxt;

  logic [7:0]           w [MAX_PATTERN];
  logic [FW-1:0]        f;
  logic [FW-1:0]        s_sel;
  logic [MAX_PATTERN-1:0] ok;
  logic [3:0]           plen, rlen;
  logic                 match;

  always_comb begin
    if (pat_len_r == 4'd0) begin
      plen = 4'd1;
    end else if (pat_len_r > 4'(MAX_PATTERN)) begin
      plen = 4'(MAX_PATTERN);
    end else begin
      plen = pat_len_r;
    end
    if (rep_len_r > 4'(MAX_REPLACEMENT)) begin
      rlen = 4'(MAX_REPLACEMENT);
    end else begin
      rlen = rep_len_r;
    end
  end

  // window with the new byte appended
  always_comb begin
    f = fill_r + FW'(1);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (FW'(i) < fill_r) begin
        w[i] = window_r[i];
      end else begin
        w[i] = in_item.in_byte;
      end
    end
  end

  // ok[s]: bytes from s up to the end of the window are a pattern prefix
  always_comb begin
    for (int s = 0; s < MAX_PATTERN; s++) begin
      ok[s] = 1'b1;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if ((s + j < MAX_PATTERN) && (FW'(s + j) < f)) begin
          if (w[s + j] != pat_bytes_r[8*j +: 8]) begin
            ok[s] = 1'b0;
          end
        end
      end
    end
    s_sel = f;
    for (int s = MAX_PATTERN - 1; s >= 0; s--) begin
      if (ok[s] && (FW'(s) < f)) begin
        s_sel = FW'(s);
      end
    end
    match = ok[0] && (4'(f) == plen);
  end

  // job, window and configuration update
  always_comb begin
    job       = '0;
    job.last  = in_item.in_last;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      job.data[8*i +: 8] = w[i];
    end
    if (match) begin
      job.data  = rep_bytes_r;
      job.count = JOB_CNT_W'(rlen);
    end else if (in_item.in_last) begin
      job.count = JOB_CNT_W'(f);
    end else begin
      job.count = JOB_CNT_W'(s_sel);
    end
    job_push = accept && in_valid && (job.count != '0);

    for (int i = 0; i < MAX_PATTERN; i++) begin
      window_nxt[i] = window_r[i];
    end
    fill_nxt      = fill_r;
    pat_bytes_nxt = pat_bytes_r;
    pat_len_nxt   = pat_len_r;
    rep_bytes_nxt = rep_bytes_r;
    rep_len_nxt   = rep_len_r;

    if (accept) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        window_nxt[i] = w[i];
        for (int k = 0; k < MAX_PATTERN; k++) begin
          if ((i + k < MAX_PATTERN) && (FW'(k) == s_sel)) begin
            window_nxt[i] = w[i + k];
          end
        end
      end
      if (match || in_item.in_last) begin
        fill_nxt = '0;
      end else begin
        fill_nxt = f - s_sel;
      end
    end

    if (cfg_wr_en) begin
      case (cfg_index)
        REG_PATTERN_BYTES: begin
          pat_bytes_nxt = cfg_data;
          fill_nxt      = '0;
        end
        REG_PATTERN_LENGTH: begin
          pat_len_nxt = cfg_data[3:0];
          fill_nxt    = '0;
        end
        REG_REPLACEMENT_BYTES: begin
          rep_bytes_nxt = cfg_data;
        end
        REG_REPLACEMENT_LENGTH: begin
          rep_len_nxt = cfg_data[3:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= 4'd1;
      rep_bytes_r <= '0;
      rep_len_r   <= '0;
      fill_r      <= '0;
    end else begin
      pat_bytes_r <= pat_bytes_nxt;
      pat_len_r   <= pat_len_nxt;
      rep_bytes_r <= rep_bytes_nxt;
      rep_len_r   <= rep_len_nxt;
      fill_r      <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      window_r[i] <= window_nxt[i];
    end
  end

endmodule

// ===== rtl/core/ssr_job_queue.sv =====
// ----------------------------------------------------------------------------
// ssr_job_queue
// Small register queue of output jobs between the front and back parts.
// ----------------------------------------------------------------------------
module ssr_job_queue
  import ssr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head,
  output q_status_t status
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  job_t              mem_r [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QLVL_W-1:0] level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      level_nxt = level_r + QLVL_W'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - QLVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign status.empty = (level_r == '0);
  assign status.full  = (level_r == QLVL_W'(QUEUE_DEPTH));
  assign status.level = level_r;

endmodule

// ===== rtl/core/ssr_back.sv =====
// ----------------------------------------------------------------------------
// ssr_back
// Plays each queued job out one byte per transfer into the output register.
// ----------------------------------------------------------------------------
module ssr_back
  import ssr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head,
  input  q_status_t q_stat,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;
  logic [JOB_IDX_W-1:0] idx_r, idx_nxt;
  logic                 load, take, final_byte;

  always_comb begin
    load       = !out_valid_r || !out_stall;
    take       = load && !q_stat.empty;
    final_byte = ({1'b0, idx_r} == (head.count - JOB_CNT_W'(1)));
    pop        = take && final_byte;

    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = !q_stat.empty;
    end
    if (take) begin
      out_item_nxt.out_byte = head.data[{idx_r, 3'b000} +: 8];
      out_item_nxt.out_last = head.last && final_byte;
      idx_nxt               = final_byte ? '0 : idx_r + JOB_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/core/stream_substring_replace_core.sv =====
// ----------------------------------------------------------------------------
// stream_substring_replace_core
// Replaces every leftmost, non-overlapping occurrence of a pattern in a byte
// stream with a replacement string.
// ----------------------------------------------------------------------------
// usage:
//   load pattern and replacement through the cfg write port while idle;
//   a pattern write clears the pending window
//   in_item carries one byte per transfer, in_last on the final byte of a
//   string; out_item carries rewritten bytes, out_last on the final one
//   (a string whose last transfer yields nothing gets no out_last)
// timing:
//   the front takes one byte per cycle while the queue is not full and turns
//   it into a job of 0 to 8 output bytes; jobs wait in a 4-entry queue; the
//   back sends one byte a cycle from the queue head into the output register
//   while out_stall is low; the first output byte is registered in the job
//   queue and then in the output register; sustained input rate is one byte
//   per cycle while each byte yields at most one output byte and the output
//   is not stalled; in_stall rises when the queue is full
// reset: rst_n, synchronous; clears the window, queue and output valid,
//   and restores the default pattern length of one
// a stalled output holds its byte; the front keeps accepting until the
//   queue fills
// ----------------------------------------------------------------------------
module stream_substring_replace_core
  import ssr_pkg::*;
#(
  parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic      accept;
  logic      job_push;
  job_t      job;
  job_t      q_head;
  q_status_t q_stat;
  logic      q_pop;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  ssr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .accept    (accept),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_push  (job_push),
    .job       (job)
  );

  ssr_job_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_stat)
  );

  ssr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // every queued job has at least one byte and fits the job width
  a_job_count: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (job.count != '0) && (job.count <= JOB_CNT_W'(JOB_MAX_BYTES)))
    else $error("job with bad byte count pushed");

  // queue level stays within depth and never pushes into a full queue
  a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.level <= QLVL_W'(QUEUE_DEPTH)) && !(job_push && q_stat.full))
    else $error("job queue overflow");

  // back never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty job queue");

  // output is idle right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule
